// ----- rtl/acp_pkg.sv -----
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types, character codes and helpers for the Accept-Charset parser.
// ----------------------------------------------------------------------------
`default_nettype none

package acp_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] VIS_LOW  = 8'h21;
    localparam logic [7:0] VIS_HIGH = 8'h7E;

    // Quality limits
    localparam logic [1:0] FRAC_MAX  = 2'd3;
    localparam logic [9:0] QUAL_FULL = 10'd1000;

    // Output word layout
    localparam int unsigned TDATA_OUT_W = 32;
    localparam int unsigned TUSER_OUT_W = 3;

    // Parser phase, one-hot
    typedef enum logic [13:0] {
        PH_START     = 14'b00_0000_0000_0001,
        PH_NAME      = 14'b00_0000_0000_0010,
        PH_OWS1      = 14'b00_0000_0000_0100,
        PH_SEMI      = 14'b00_0000_0000_1000,
        PH_OWS2      = 14'b00_0000_0001_0000,
        PH_Q         = 14'b00_0000_0010_0000,
        PH_EQ        = 14'b00_0000_0100_0000,
        PH_ONE_INT   = 14'b00_0000_1000_0000,
        PH_ONE_FRAC  = 14'b00_0001_0000_0000,
        PH_ZERO_INT  = 14'b00_0010_0000_0000,
        PH_ZERO_FRAC = 14'b00_0100_0000_0000,
        PH_AFTER     = 14'b00_1000_0000_0000,
        PH_HALT      = 14'b01_0000_0000_0000,
        PH_DONE      = 14'b10_0000_0000_0000
    } t_phase;

    // Per-entry parser state (name count kept apart, its width is a parameter)
    typedef struct packed {
        t_phase     phase;
        logic [1:0] frac_cnt;
        logic [9:0] qacc;
        logic       first_ast;
        logic       q_one;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:     PH_START,
        frac_cnt:  2'd0,
        qacc:      10'd0,
        first_ast: 1'b0,
        q_one:     1'b1
    };

    // One result word
    typedef struct packed {
        logic       name_byte_valid;
        logic [7:0] name_byte;
        logic       entry_done;
        logic [6:0] name_length;
        logic [9:0] quality_thousandths;
        logic       wildcard_res;
        logic       header_done;
        logic       syntax_error;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= VIS_LOW) && (c <= VIS_HIGH) && (c != CH_SEMI);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/acp_step.sv -----
// ----------------------------------------------------------------------------
// acp_step
// Next-state and result logic of the parser for one header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module acp_step #(
    parameter int unsigned MAX_NAME_LEN = 64,
    parameter int unsigned CNT_W        = $clog2(MAX_NAME_LEN + 1)
) (
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_first,
    input  wire acp_pkg::t_state  i_state,
    input  wire logic [CNT_W-1:0] i_cnt,
    output acp_pkg::t_state       o_state,
    output logic      [CNT_W-1:0] o_cnt,
    output acp_pkg::t_result      o_res
);
    import acp_pkg::*;

    t_state           w_st;
    logic [CNT_W-1:0] w_cnt;
    t_state           n_st;
    logic [CNT_W-1:0] n_cnt;
    t_result          res;
    logic             do_name;
    logic             try_close;
    logic             err;
    logic             start_entry;
    logic             frac_ok;
    logic [3:0]       digit;
    logic [9:0]       addend;
    logic [CNT_W+6:0] len_ext;

    assign digit   = i_byte[3:0];
    assign len_ext = {7'd0, w_cnt};

    always_comb begin
        // Restart on first byte, then clear the entry where a new one opens
        w_st  = i_first ? STATE_RESET : i_state;
        w_cnt = i_first ? '0 : i_cnt;
        start_entry = (w_st.phase == PH_START) ||
                      ((w_st.phase == PH_AFTER) && !is_space(i_byte) &&
                       (i_byte != CH_COMMA) && (i_byte != CH_NUL));
        if (start_entry) begin
            w_st.frac_cnt  = 2'd0;
            w_st.qacc      = 10'd0;
            w_st.first_ast = 1'b0;
            w_st.q_one     = 1'b1;
            w_cnt          = '0;
        end

        n_st      = w_st;
        n_cnt     = w_cnt;
        res       = '0;
        do_name   = 1'b0;
        try_close = 1'b0;
        err       = 1'b0;
        frac_ok   = 1'b0;
        addend    = 10'd0;

        case (w_st.phase)
            PH_START: begin
                if (is_name_char(i_byte)) begin
                    do_name = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            PH_NAME: begin
                do_name = 1'b1;
            end
            PH_OWS1: begin
                if (i_byte == CH_SEMI) begin
                    n_st.phase = PH_SEMI;
                end else if (!is_space(i_byte)) begin
                    err = 1'b1;
                end
            end
            PH_SEMI, PH_OWS2: begin
                if (is_space(i_byte)) begin
                    n_st.phase = PH_OWS2;
                end else if (i_byte == CH_Q) begin
                    n_st.phase = PH_Q;
                end else begin
                    err = 1'b1;
                end
            end
            PH_Q: begin
                if (i_byte == CH_EQUAL) begin
                    n_st.phase = PH_EQ;
                end else begin
                    err = 1'b1;
                end
            end
            PH_EQ: begin
                if (i_byte == CH_ONE) begin
                    n_st.q_one = 1'b1;
                    n_st.phase = PH_ONE_INT;
                end else if (i_byte == CH_ZERO) begin
                    n_st.q_one = 1'b0;
                    n_st.qacc  = 10'd0;
                    n_st.phase = PH_ZERO_INT;
                end else begin
                    err = 1'b1;
                end
            end
            PH_ONE_INT, PH_ZERO_INT: begin
                if (i_byte == CH_POINT) begin
                    n_st.frac_cnt = 2'd0;
                    n_st.phase    = (w_st.phase == PH_ONE_INT) ? PH_ONE_FRAC
                                                               : PH_ZERO_FRAC;
                end else begin
                    try_close = 1'b1;
                end
            end
            PH_ONE_FRAC, PH_ZERO_FRAC: begin
                frac_ok = (w_st.phase == PH_ONE_FRAC) ? (i_byte == CH_ZERO)
                                                      : is_digit(i_byte);
                if (frac_ok) begin
                    if (w_st.frac_cnt == FRAC_MAX) begin
                        err = 1'b1;
                    end else begin
                        // Weight the digit by its place after the point
                        case (w_st.frac_cnt)
                            2'd0:    addend = {6'd0, digit} * 10'd100;
                            2'd1:    addend = {6'd0, digit} * 10'd10;
                            default: addend = {6'd0, digit};
                        endcase
                        n_st.qacc     = w_st.qacc + addend;
                        n_st.frac_cnt = w_st.frac_cnt + 2'd1;
                    end
                end else begin
                    try_close = 1'b1;
                end
            end
            PH_AFTER: begin
                if (i_byte == CH_NUL) begin
                    res.header_done = 1'b1;
                    n_st.phase      = PH_DONE;
                end else if (!is_space(i_byte) && (i_byte != CH_COMMA)) begin
                    if (is_name_char(i_byte)) begin
                        do_name = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            default: begin
                // Halted or finished: hold until the next first byte
            end
        endcase

        // Name byte: close, separator, or store
        if (do_name) begin
            if ((i_byte == CH_COMMA) || (i_byte == CH_NUL)) begin
                try_close = 1'b1;
            end else if (i_byte == CH_SEMI) begin
                n_st.phase = PH_SEMI;
            end else if (is_space(i_byte)) begin
                n_st.phase = PH_OWS1;
            end else if (!is_name_char(i_byte)) begin
                err = 1'b1;
            end else begin
                n_st.phase = PH_NAME;
                if (w_cnt < CNT_W'(MAX_NAME_LEN)) begin
                    if (w_cnt == '0) begin
                        n_st.first_ast = (i_byte == CH_STAR);
                    end
                    n_cnt               = w_cnt + CNT_W'(1);
                    res.name_byte_valid = 1'b1;
                    res.name_byte       = i_byte;
                end
            end
        end

        // Close the entry on comma or end of value
        if (try_close) begin
            if ((i_byte == CH_COMMA) || (i_byte == CH_NUL)) begin
                res.entry_done          = 1'b1;
                res.name_length         = len_ext[6:0];
                res.quality_thousandths = w_st.q_one ? QUAL_FULL : w_st.qacc;
                res.wildcard_res        = (w_cnt == CNT_W'(1)) && w_st.first_ast;
                if (i_byte == CH_COMMA) begin
                    n_st.frac_cnt  = 2'd0;
                    n_st.qacc      = 10'd0;
                    n_st.first_ast = 1'b0;
                    n_st.q_one     = 1'b1;
                    n_cnt          = '0;
                    n_st.phase     = PH_AFTER;
                end else begin
                    res.header_done = 1'b1;
                    n_st.phase      = PH_DONE;
                end
            end else begin
                err = 1'b1;
            end
        end

        // Drop the result and halt on a grammar violation
        if (err) begin
            res              = '0;
            res.syntax_error = 1'b1;
            n_st.phase       = PH_HALT;
        end
    end

    assign o_state = n_st;
    assign o_cnt   = n_cnt;
    assign o_res   = res;

endmodule

`default_nettype wire

// ----- rtl/accept_charset_header_parser.sv -----
// ----------------------------------------------------------------------------
// accept_charset_header_parser
// Byte-stream parser for Accept-Charset header values.
// ----------------------------------------------------------------------------
// One header byte enters per word and one result word leaves for it; a new
// byte is taken every clock cycle while the output is not stalled. The
// rate is set by the parser state loop, which advances once per byte through
// a single stage of logic between the input register and the result register.
// The output register lets a new byte enter while a result waits to be taken.
// A first_byte flag restarts parsing; after a syntax error or a completed
// header every byte yields an all-zero result until the next first byte.
`default_nettype none

module accept_charset_header_parser #(
    parameter int unsigned MAX_NAME_LEN = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] header_byte
    input  wire logic [0:0]  i_s_tuser,   // [0] first_byte
    // Output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [acp_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    // [7:0] name_byte, [14:8] name_length, [24:15] quality_thousandths,
    // [25] wildcard_res, [31:26] zero
    output logic [acp_pkg::TUSER_OUT_W-1:0] o_m_tuser,
    // [0] name_byte_valid, [1] entry_done, [2] syntax_error
    output logic             o_m_tlast    // header_done
);
    import acp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_NAME_LEN + 1);

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_first;
    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    t_result          r_res;

    t_state           n_state;
    logic [CNT_W-1:0] n_cnt;
    t_result          n_res;

    logic             s_accept;
    logic             advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    acp_step #(
        .MAX_NAME_LEN (MAX_NAME_LEN),
        .CNT_W        (CNT_W)
    ) u_step (
        .i_byte  (r_byte),
        .i_first (r_first),
        .i_state (r_state),
        .i_cnt   (r_cnt),
        .o_state (n_state),
        .o_cnt   (n_cnt),
        .o_res   (n_res)
    );

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_byte  <= i_s_tdata;
            r_first <= i_s_tuser[0];
        end
    end

    // Advance parser state once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cnt   <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_res.wildcard_res, r_res.quality_thousandths,
                         r_res.name_length, r_res.name_byte};
    assign o_m_tuser  = {r_res.syntax_error, r_res.entry_done, r_res.name_byte_valid};
    assign o_m_tlast  = r_res.header_done;

endmodule

`default_nettype wire
